/* rtl/bdmc_pkg.sv */
// ============================================================================
// bdmc_pkg
// Shared types, constants and type-name decode for the bar-delimited
// message checker.
// ============================================================================
package bdmc_pkg;

    localparam int MAX_FRAME = 104;
    localparam int MAX_BODY  = MAX_FRAME - 10;
    localparam int HDR_LEN   = 5;

    localparam logic [7:0] CH_BAR  = 8'h7C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [31:0] NAME_WAIT = 32'h5741_4954;
    localparam logic [31:0] NAME_OPEN = 32'h4F50_454E;
    localparam logic [31:0] NAME_FAIL = 32'h4641_494C;
    localparam logic [31:0] NAME_NAME = 32'h4E41_4D45;
    localparam logic [31:0] NAME_PLAY = 32'h504C_4159;
    localparam logic [31:0] NAME_MOVE = 32'h4D4F_5645;
    localparam logic [31:0] NAME_OVER = 32'h4F56_4552;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_WAIT = 3'd1,
        KIND_OPEN = 3'd2,
        KIND_FAIL = 3'd3,
        KIND_NAME = 3'd4,
        KIND_PLAY = 3'd5,
        KIND_MOVE = 3'd6,
        KIND_OVER = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2,
        ST_LOST     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_VERSION = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_TYPE    = 4'b0100,
        PH_BODY    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_body;
        logic [1:0] field_index;
        logic       field_end;
        t_kind      type_code;
        t_status    status;
    } t_result;

    function automatic t_kind kind_of(input logic [31:0] letters);
        t_kind k;
        k = KIND_NONE;
        case (letters)
            NAME_WAIT: k = KIND_WAIT;
            NAME_OPEN: k = KIND_OPEN;
            NAME_FAIL: k = KIND_FAIL;
            NAME_NAME: k = KIND_NAME;
            NAME_PLAY: k = KIND_PLAY;
            NAME_MOVE: k = KIND_MOVE;
            NAME_OVER: k = KIND_OVER;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] fields_of(input t_kind k);
        logic [1:0] n;
        case (k)
            KIND_OPEN, KIND_FAIL:            n = 2'd1;
            KIND_NAME, KIND_PLAY, KIND_MOVE: n = 2'd2;
            KIND_OVER:                       n = 2'd3;
            default:                         n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/bdmc_frame_fsm.sv */
// ============================================================================
// bdmc_frame_fsm
// Frame state and per-byte check: one item in, one result out, state
// advanced when the step strobe is high.
// ============================================================================
module bdmc_frame_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_link_lost,
    output bdmc_pkg::t_result o_result
);
    import bdmc_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [6:0]  r_position, n_position;
    logic [3:0]  r_tens,     n_tens;
    logic [6:0]  r_body_len, n_body_len;
    logic [31:0] r_letters,  n_letters;
    logic [1:0]  r_expected, n_expected;
    logic [1:0]  r_bars,     n_bars;
    t_kind       r_kind,     n_kind;

    logic       is_bar;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] raw_len;
    t_kind      found;
    logic [1:0] found_fields;
    logic [7:0] count;
    logic [2:0] nb;
    t_result    res;

    assign is_bar       = (i_rx_byte == CH_BAR);
    assign is_digit     = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit        = i_rx_byte[3:0];
    assign raw_len      = 7'(({3'd0, r_tens} * 7'd10) + {3'd0, digit});
    assign found        = kind_of(r_letters);
    assign found_fields = fields_of(found);
    assign count        = {1'b0, r_position} + 8'd1;
    assign nb           = {1'b0, r_bars} + {2'd0, is_bar};

    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_tens     = r_tens;
        n_body_len = r_body_len;
        n_letters  = r_letters;
        n_expected = r_expected;
        n_bars     = r_bars;
        n_kind     = r_kind;

        res.data_byte   = i_rx_byte;
        res.in_body     = 1'b0;
        res.field_index = 2'd0;
        res.field_end   = 1'b0;
        res.type_code   = r_kind;
        res.status      = ST_BUSY;

        if (i_link_lost) begin
            res.data_byte = 8'd0;
            res.status    = ST_LOST;
        end else begin
            case (r_phase)
                PH_VERSION: begin
                    if (r_position == 7'd0) begin
                        if (i_rx_byte != CH_ZERO) res.status = ST_INVALID;
                        else n_position = 7'd1;
                    end else if (!is_bar) begin
                        res.status = ST_INVALID;
                    end else begin
                        n_phase    = PH_LENGTH;
                        n_position = 7'd0;
                    end
                end
                PH_LENGTH: begin
                    if (r_position < 7'd2) begin
                        if (!is_digit) begin
                            res.status = ST_INVALID;
                        end else if (r_position == 7'd0) begin
                            n_tens     = digit;
                            n_position = 7'd1;
                        end else begin
                            n_body_len = raw_len;
                            n_position = 7'd2;
                        end
                    end else if (!is_bar || (r_body_len < 7'(HDR_LEN))
                                 || ({1'b0, r_body_len} > 8'(MAX_BODY + HDR_LEN))) begin
                        res.status = ST_INVALID;
                    end else begin
                        n_body_len = r_body_len - 7'(HDR_LEN);
                        n_phase    = PH_TYPE;
                        n_position = 7'd0;
                    end
                end
                PH_TYPE: begin
                    if (r_position < 7'd4) begin
                        if (is_bar) begin
                            res.status = ST_INVALID;
                        end else begin
                            n_letters  = {r_letters[23:0], i_rx_byte};
                            n_position = r_position + 7'd1;
                        end
                    end else if (!is_bar || (found == KIND_NONE)) begin
                        res.status = ST_INVALID;
                    end else begin
                        n_kind        = found;
                        res.type_code = found;
                        n_expected    = found_fields;
                        if (r_body_len == 7'd0) begin
                            res.status = (found_fields == 2'd0) ? ST_COMPLETE : ST_INVALID;
                        end else begin
                            n_phase    = PH_BODY;
                            n_position = 7'd0;
                            n_bars     = 2'd0;
                        end
                    end
                end
                PH_BODY: begin
                    if (nb > {1'b0, r_expected}) begin
                        res.status = ST_INVALID;
                    end else if (count < {1'b0, r_body_len}) begin
                        if (nb == {1'b0, r_expected}) begin
                            res.status = ST_INVALID;
                        end else begin
                            res.in_body     = 1'b1;
                            res.field_index = r_bars;
                            res.field_end   = is_bar;
                            n_bars          = nb[1:0];
                            n_position      = count[6:0];
                        end
                    end else if (!is_bar || (nb != {1'b0, r_expected})) begin
                        res.status = ST_INVALID;
                    end else begin
                        res.in_body     = 1'b1;
                        res.field_index = r_bars;
                        res.field_end   = 1'b1;
                        res.status      = ST_COMPLETE;
                    end
                end
                default: begin
                    res.status = ST_INVALID;
                end
            endcase
        end

        if (res.status != ST_BUSY) begin
            n_phase    = PH_VERSION;
            n_position = 7'd0;
            n_tens     = 4'd0;
            n_body_len = 7'd0;
            n_letters  = 32'd0;
            n_expected = 2'd0;
            n_bars     = 2'd0;
            n_kind     = KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VERSION;
            r_position <= 7'd0;
            r_tens     <= 4'd0;
            r_body_len <= 7'd0;
            r_letters  <= 32'd0;
            r_expected <= 2'd0;
            r_bars     <= 2'd0;
            r_kind     <= KIND_NONE;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_tens     <= n_tens;
            r_body_len <= n_body_len;
            r_letters  <= n_letters;
            r_expected <= n_expected;
            r_bars     <= n_bars;
            r_kind     <= n_kind;
        end
    end

    assign o_result = res;

endmodule

/* rtl/bar_delimited_message_checker_core.sv */
// ============================================================================
// bar_delimited_message_checker_core
// Checks bar-delimited message frames one received byte at a time.
// ============================================================================
// Every item accepted gives exactly one result item. An item passes through
// an input register, the frame check and a result register, and one item is
// taken every cycle while the output side keeps tready high; the frame state
// is updated once per item as it moves from the input to the result register.
module bar_delimited_message_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    input  logic        s_axis_tuser,  // link_lost
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // data_byte, type_code, status, zero pad
    output logic [2:0]  m_axis_tuser,  // in_body, field_index
    output logic        m_axis_tlast   // field_end
);
    import bdmc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_lost;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       step;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (step) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_lost <= s_axis_tuser;
        end
        if (step) r_out <= step_res;
    end

    bdmc_frame_fsm u_frame_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rx_byte   (r_in_byte),
        .i_link_lost (r_in_lost),
        .o_result    (step_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.status, r_out.type_code, r_out.data_byte};
    assign m_axis_tuser  = {r_out.field_index, r_out.in_body};
    assign m_axis_tlast  = r_out.field_end;

endmodule

/* tb/sv/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the bar-delimited message checker. A queue of
// received bytes (directed frames, well-formed random frames, faulty frames
// and noise) drives the input stream. Each accepted item is run through a
// frame predictor held here, and every result item is checked field by field
// against the oldest prediction. Both sides idle at random.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdmc_pkg::*;

    localparam int RANDOM_ITEMS = 770;
    localparam int CALM_TAIL    = 120;

    typedef struct {
        logic [7:0] rx;
        logic       lost;
        logic       hold;
    } t_rx_item;

    typedef enum int {
        FAULT_NONE  = 0,
        FAULT_SWAP  = 1,
        FAULT_BAR   = 2,
        FAULT_DROP  = 3,
        FAULT_CUT   = 4,
        FAULT_EMPTY = 5
    } t_fault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // rx_byte
    logic        s_axis_tuser = 1'b0;   // link_lost
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // data_byte, type_code, status, zero pad
    logic [2:0]  m_axis_tuser;          // in_body, field_index
    logic        m_axis_tlast;          // field_end

    t_rx_item rx_pending[$];
    t_result  due_results[$];
    int       queued = 0;
    int       mismatches = 0;
    int       tx_gap = 0;
    int       rx_stall = 0;
    logic     hold_next = 1'b0;

    t_phase      fr_phase;
    logic [6:0]  fr_pos;
    logic [3:0]  fr_tens;
    logic [6:0]  fr_len;
    logic [31:0] fr_letters;
    logic [1:0]  fr_nfields;
    logic [1:0]  fr_bars;
    t_kind       fr_kind;

    bar_delimited_message_checker_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] letters_for(input t_kind k);
        case (k)
            KIND_WAIT: return NAME_WAIT;
            KIND_OPEN: return NAME_OPEN;
            KIND_FAIL: return NAME_FAIL;
            KIND_NAME: return NAME_NAME;
            KIND_PLAY: return NAME_PLAY;
            KIND_MOVE: return NAME_MOVE;
            KIND_OVER: return NAME_OVER;
            default:   return 32'h0;
        endcase
    endfunction

    function automatic int fields_in(input t_kind k);
        case (k)
            KIND_OPEN, KIND_FAIL:            return 1;
            KIND_NAME, KIND_PLAY, KIND_MOVE: return 2;
            KIND_OVER:                       return 3;
            default:                         return 0;
        endcase
    endfunction

    function automatic void frame_restart();
        fr_phase   = PH_VERSION;
        fr_pos     = '0;
        fr_tens    = '0;
        fr_len     = '0;
        fr_letters = '0;
        fr_nfields = '0;
        fr_bars    = '0;
        fr_kind    = KIND_NONE;
    endfunction

    function automatic t_result frame_step(input logic [7:0] b, input logic lost);
        t_result r;
        logic    bar;
        int      count;
        int      nb;
        t_kind   found;
        bar = (b == CH_BAR);
        r = '0;
        r.data_byte = b;
        r.type_code = fr_kind;
        r.status = ST_BUSY;
        if (lost) begin
            r.data_byte = 8'h00;
            r.status = ST_LOST;
        end else begin
            case (fr_phase)
                PH_VERSION: begin
                    if (fr_pos == 0) begin
                        if (b != CH_ZERO) r.status = ST_INVALID;
                        else fr_pos = 7'd1;
                    end else if (!bar) begin
                        r.status = ST_INVALID;
                    end else begin
                        fr_phase = PH_LENGTH;
                        fr_pos = '0;
                    end
                end
                PH_LENGTH: begin
                    if (fr_pos < 2) begin
                        if (b < CH_ZERO || b > CH_NINE) begin
                            r.status = ST_INVALID;
                        end else if (fr_pos == 0) begin
                            fr_tens = 4'(b - CH_ZERO);
                            fr_pos = 7'd1;
                        end else begin
                            fr_len = 7'(int'(fr_tens) * 10 + int'(b - CH_ZERO));
                            fr_pos = 7'd2;
                        end
                    end else if (!bar || int'(fr_len) < HDR_LEN ||
                                 int'(fr_len) - HDR_LEN > MAX_BODY) begin
                        r.status = ST_INVALID;
                    end else begin
                        fr_len = 7'(int'(fr_len) - HDR_LEN);
                        fr_phase = PH_TYPE;
                        fr_pos = '0;
                    end
                end
                PH_TYPE: begin
                    if (fr_pos < 4) begin
                        if (bar) begin
                            r.status = ST_INVALID;
                        end else begin
                            fr_letters = {fr_letters[23:0], b};
                            fr_pos = fr_pos + 7'd1;
                        end
                    end else if (!bar) begin
                        r.status = ST_INVALID;
                    end else begin
                        found = KIND_NONE;
                        for (int k = 1; k < 8; k++) begin
                            if (fr_letters == letters_for(t_kind'(k))) found = t_kind'(k);
                        end
                        if (found == KIND_NONE) begin
                            r.status = ST_INVALID;
                        end else begin
                            fr_kind = found;
                            r.type_code = found;
                            fr_nfields = 2'(fields_in(found));
                            if (fr_len == 0) begin
                                r.status = (fr_nfields == 0) ? ST_COMPLETE : ST_INVALID;
                            end else begin
                                fr_phase = PH_BODY;
                                fr_pos = '0;
                                fr_bars = '0;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    count = int'(fr_pos) + 1;
                    nb = int'(fr_bars) + (bar ? 1 : 0);
                    if (nb > int'(fr_nfields)) begin
                        r.status = ST_INVALID;
                    end else if (count < int'(fr_len)) begin
                        if (nb == int'(fr_nfields)) begin
                            r.status = ST_INVALID;
                        end else begin
                            r.in_body = 1'b1;
                            r.field_index = fr_bars;
                            r.field_end = bar;
                            fr_bars = 2'(nb);
                            fr_pos = 7'(count);
                        end
                    end else if (!bar || nb != int'(fr_nfields)) begin
                        r.status = ST_INVALID;
                    end else begin
                        r.in_body = 1'b1;
                        r.field_index = fr_bars;
                        r.field_end = 1'b1;
                        r.status = ST_COMPLETE;
                    end
                end
                default: r.status = ST_INVALID;
            endcase
        end
        if (r.status != ST_BUSY) frame_restart();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40) $display("%0t ns %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_BAR);
        return b;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic lost);
        t_rx_item it;
        it.rx = b;
        it.lost = lost;
        it.hold = hold_next;
        hold_next = 1'b0;
        rx_pending.push_back(it);
        queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
    endtask

    task automatic queue_frame(input t_kind k, input int hi, input int skew,
                               input t_fault fault);
        logic [7:0]  fr[$];
        logic [7:0]  body[$];
        logic [31:0] letters;
        int          nf;
        int          len;
        int          pos;
        int          lost_at;
        lost_at = -1;
        nf = (k == KIND_NONE) ? $urandom_range(0, 3) : fields_in(k);
        for (int f = 0; f < nf; f++) begin
            repeat ($urandom_range(0, hi)) body.push_back(plain_byte());
            body.push_back(CH_BAR);
        end
        if (fault == FAULT_EMPTY) body.delete();
        if (k == KIND_NONE) begin
            for (int i = 0; i < 4; i++) letters = {letters[23:0], 8'($urandom_range(65, 90))};
        end else begin
            letters = letters_for(k);
        end
        len = body.size() + HDR_LEN + skew;
        if (len < 0) len = 0;
        if (len > 99) len = 99;
        fr.push_back(CH_ZERO);
        fr.push_back(CH_BAR);
        fr.push_back(8'(CH_ZERO + len / 10));
        fr.push_back(8'(CH_ZERO + len % 10));
        fr.push_back(CH_BAR);
        fr.push_back(letters[31:24]);
        fr.push_back(letters[23:16]);
        fr.push_back(letters[15:8]);
        fr.push_back(letters[7:0]);
        fr.push_back(CH_BAR);
        foreach (body[i]) fr.push_back(body[i]);
        pos = $urandom_range(0, fr.size() - 1);
        case (fault)
            FAULT_SWAP: fr[pos] = 8'($urandom_range(0, 255));
            FAULT_BAR:  fr.insert(pos, CH_BAR);
            FAULT_DROP: lost_at = pos;
            FAULT_CUT:  while (fr.size() > pos + 1) void'(fr.pop_back());
            default: ;
        endcase
        foreach (fr[i]) begin
            if (i == lost_at) queue_byte(8'($urandom_range(0, 255)), 1'b1);
            queue_byte(fr[i], 1'b0);
        end
    endtask

    always @(posedge i_clk) begin : sender
        t_rx_item nxt;
        logic     drive;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(frame_step(s_axis_tdata, s_axis_tuser));
            if (!s_axis_tvalid || s_axis_tready) begin
                drive = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (rx_pending.size() > 0 &&
                             !(rx_pending[0].hold && due_results.size() != 0)) begin
                    drive = 1'b1;
                    nxt = rx_pending.pop_front();
                    if (rx_pending.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 11);
                end
                s_axis_tvalid <= drive;
                if (drive) begin
                    s_axis_tdata <= nxt.rx;
                    s_axis_tuser <= nxt.lost;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result item with nothing due", m_axis_tdata, 0);
                end else begin
                    want = due_results.pop_front();
                    check_field("data_byte", m_axis_tdata[7:0], want.data_byte);
                    check_field("type_code", m_axis_tdata[10:8], want.type_code);
                    check_field("status", m_axis_tdata[12:11], want.status);
                    check_field("in_body", m_axis_tuser[0], want.in_body);
                    check_field("field_index", m_axis_tuser[2:1], want.field_index);
                    check_field("field_end", m_axis_tlast, want.field_end);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else if (rx_pending.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                rx_stall = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int r;
        int last;
        frame_restart();

        // directed: empty wait body, single empty field, link drop, bad version,
        // bar in place of a length digit
        queue_text("0|05|WAIT|");
        queue_text("0|06|OPEN||");
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_text("0||");

        // longest body, sent once the pipe has drained
        hold_next = 1'b1;
        queue_text("0|99|OVER|");
        for (int f = 0; f < 3; f++) begin
            repeat ((f == 2) ? 29 : 31) queue_byte(plain_byte(), 1'b0);
            queue_byte(CH_BAR, 1'b0);
        end

        last = queued + RANDOM_ITEMS;
        while (queued < last) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
                    else queue_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                if ($urandom_range(0, 29) == 0) hold_next = 1'b1;
                queue_frame((r < 14) ? KIND_NONE : t_kind'($urandom_range(1, 7)),
                            ($urandom_range(0, 19) == 0) ? 20 : 4,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) - 6 : 0,
                            ($urandom_range(0, 4) == 0) ? t_fault'($urandom_range(1, 5))
                                                        : FAULT_NONE);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (rx_pending.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bar_delimited_message_checker_core: match");
        end else begin
            $display("bar_delimited_message_checker_core: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("bar_delimited_message_checker_core: mismatch");
        $finish;
    end

endmodule
